>>> hdl/hsa_pkg.sv
// Package for the HSV saturation adjust pipeline.
// Holds the widths and the stage record that the divider stages use. No dependencies.
package hsa_pkg;

   localparam int CH_BITS     = 8;
   localparam int FRAC_BITS   = 8;
   localparam int FACTOR_BITS = 16;
   localparam int K_BITS      = CH_BITS + FRAC_BITS;
   localparam int DEN_BITS    = CH_BITS + FRAC_BITS;
   localparam int NUM_BITS    = 2 * CH_BITS + FRAC_BITS;
   localparam int CHANNELS    = 3;

   // One transaction as it moves through the divider stages
   typedef struct packed {
      logic                                valid;
      logic                                gray;
      logic [CH_BITS-1:0]                  alpha;
      logic [CH_BITS-1:0]                  value;
      logic [CHANNELS-1:0][CH_BITS-1:0]    raw;
      logic [CHANNELS-1:0][NUM_BITS-1:0]   rem;
      logic [DEN_BITS-1:0]                 den;
      logic [CHANNELS-1:0][CH_BITS-1:0]    quo;
   } hsa_div_type;

endpackage

>>> hdl/hsa_front.sv
// Front end of the saturation adjust pipeline: value and chroma, new chroma, numerators.
// Three register stages; depends on hsa_pkg.
module hsa_front import hsa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [CH_BITS-1:0]       red,
   input  logic [CH_BITS-1:0]       green,
   input  logic [CH_BITS-1:0]       blue,
   input  logic [CH_BITS-1:0]       alpha,
   input  logic [FACTOR_BITS-1:0]   factor,
   output hsa_div_type              out
);

   // stage 1: max, min, chroma
   logic                                s1_valid_ff;
   logic [CHANNELS-1:0][CH_BITS-1:0]    s1_raw_ff;
   logic [CH_BITS-1:0]                  s1_alpha_ff, s1_v_ff, s1_d_ff;
   logic [FACTOR_BITS-1:0]              s1_f_ff;
   logic [CH_BITS-1:0]                  mx_in, mn_in, rg_max, rg_min;

   always_comb begin
      rg_max = (red > green) ? red : green;
      rg_min = (red < green) ? red : green;
      mx_in  = (rg_max > blue) ? rg_max : blue;
      mn_in  = (rg_min < blue) ? rg_min : blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
      if (en) begin
         s1_raw_ff   <= {blue, green, red};
         s1_alpha_ff <= alpha;
         s1_v_ff     <= mx_in;
         s1_d_ff     <= mx_in - mn_in;
         s1_f_ff     <= factor;
      end
   end

   // stage 2: new chroma clamped to value, and value times chroma
   logic                                s2_valid_ff;
   logic [CHANNELS-1:0][CH_BITS-1:0]    s2_raw_ff;
   logic [CH_BITS-1:0]                  s2_alpha_ff, s2_v_ff, s2_d_ff;
   logic [K_BITS-1:0]                   s2_k_ff;
   logic [2*CH_BITS-1:0]                s2_vd_ff;
   logic [CH_BITS+FACTOR_BITS-1:0]      kfull_in;
   logic [K_BITS-1:0]                   kmax_in, k_in;

   always_comb begin
      kfull_in = (CH_BITS+FACTOR_BITS)'(s1_d_ff) * (CH_BITS+FACTOR_BITS)'(s1_f_ff);
      kmax_in  = {s1_v_ff, {FRAC_BITS{1'b0}}};
      if (kfull_in > (CH_BITS+FACTOR_BITS)'(kmax_in)) begin
         k_in = kmax_in;
      end else begin
         k_in = kfull_in[K_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_raw_ff   <= s1_raw_ff;
         s2_alpha_ff <= s1_alpha_ff;
         s2_v_ff     <= s1_v_ff;
         s2_d_ff     <= s1_d_ff;
         s2_k_ff     <= k_in;
         s2_vd_ff    <= (2*CH_BITS)'(s1_v_ff) * (2*CH_BITS)'(s1_d_ff);
      end
   end

   // stage 3: rounded numerators over the shared denominator
   hsa_div_type s3_ff, s3_in;
   logic [NUM_BITS-1:0] base;

   always_comb begin
      base = {s2_vd_ff, {FRAC_BITS{1'b0}}}
           + NUM_BITS'({s2_d_ff, {(FRAC_BITS-1){1'b0}}});
      s3_in.valid = s2_valid_ff;
      s3_in.gray  = (s2_d_ff == '0);
      s3_in.alpha = s2_alpha_ff;
      s3_in.value = s2_v_ff;
      s3_in.raw   = s2_raw_ff;
      s3_in.den   = {s2_d_ff, {FRAC_BITS{1'b0}}};
      s3_in.quo   = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         s3_in.rem[c] = base - NUM_BITS'(s2_k_ff) * NUM_BITS'(s2_v_ff - s2_raw_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (en) begin
         s3_ff.valid <= s3_in.valid;
      end
      if (en) begin
         s3_ff.gray  <= s3_in.gray;
         s3_ff.alpha <= s3_in.alpha;
         s3_ff.value <= s3_in.value;
         s3_ff.raw   <= s3_in.raw;
         s3_ff.rem   <= s3_in.rem;
         s3_ff.den   <= s3_in.den;
         s3_ff.quo   <= s3_in.quo;
      end
   end

   assign out = s3_ff;

   a_valid_moves: assert property (@(posedge clock) disable iff (reset)
      en && s1_valid_ff |=> s2_valid_ff)
      else $error("stage 1 transaction lost on advance");

   a_chroma_bounded: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_k_ff <= {s2_v_ff, {FRAC_BITS{1'b0}}})
      else $error("new chroma exceeds value");

endmodule

>>> hdl/hsa_div_stage.sv
// One restoring division step for all three channels: one quotient bit per stage.
// Depends on hsa_pkg.
module hsa_div_stage import hsa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  hsa_div_type  in,
   output hsa_div_type  out
);

   hsa_div_type stage_ff, stage_in;
   logic [NUM_BITS-1:0] dshift;
   logic [NUM_BITS-1:0] diff;

   always_comb begin
      stage_in = in;
      dshift   = NUM_BITS'({in.den, {(CH_BITS-1){1'b0}}});
      diff     = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         diff = in.rem[c] - dshift;
         if (in.rem[c] >= dshift) begin
            stage_in.rem[c] = {diff[NUM_BITS-2:0], 1'b0};
            stage_in.quo[c] = {in.quo[c][CH_BITS-2:0], 1'b1};
         end else begin
            stage_in.rem[c] = {in.rem[c][NUM_BITS-2:0], 1'b0};
            stage_in.quo[c] = {in.quo[c][CH_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (en) begin
         stage_ff.gray  <= stage_in.gray;
         stage_ff.alpha <= stage_in.alpha;
         stage_ff.value <= stage_in.value;
         stage_ff.raw   <= stage_in.raw;
         stage_ff.rem   <= stage_in.rem;
         stage_ff.den   <= stage_in.den;
         stage_ff.quo   <= stage_in.quo;
      end
   end

   assign out = stage_ff;

endmodule

>>> hdl/hsv_saturation_adjust.sv
// HSV saturation adjust for one RGBA pixel per transaction.
// Depends on hsa_pkg, hsa_front and hsa_div_stage.

// Takes one pixel per clock while no result waits on rsp_ready. Three front stages
// (max/min and chroma, new chroma multiply, numerator multiply) then eight
// restoring divider stages, one quotient bit each. The whole pipeline
// advances together and holds while a result waits on rsp_ready; the last
// divider stage is the output register.
module hsv_saturation_adjust import hsa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CH_BITS-1:0]      req_red_in,
   input  logic [CH_BITS-1:0]      req_green_in,
   input  logic [CH_BITS-1:0]      req_blue_in,
   input  logic [CH_BITS-1:0]      req_alpha_in,
   input  logic [FACTOR_BITS-1:0]  req_sat_factor,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [CH_BITS-1:0]      rsp_red_out,
   output logic [CH_BITS-1:0]      rsp_green_out,
   output logic [CH_BITS-1:0]      rsp_blue_out,
   output logic [CH_BITS-1:0]      rsp_alpha_out
);

   hsa_div_type chain [CH_BITS+1];
   logic        en;

   // advance unless a finished transaction is still waiting
   assign en        = !chain[CH_BITS].valid || rsp_ready;
   assign req_ready = en;

   hsa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .red      (req_red_in),
      .green    (req_green_in),
      .blue     (req_blue_in),
      .alpha    (req_alpha_in),
      .factor   (req_sat_factor),
      .out      (chain[0])
   );

   for (genvar i = 0; i < CH_BITS; i++) begin : g_div
      hsa_div_stage u_stage (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .in    (chain[i]),
         .out   (chain[i+1])
      );
   end

   // gray pixels pass unchanged
   assign rsp_valid     = chain[CH_BITS].valid;
   assign rsp_red_out   = chain[CH_BITS].gray ? chain[CH_BITS].raw[0] : chain[CH_BITS].quo[0];
   assign rsp_green_out = chain[CH_BITS].gray ? chain[CH_BITS].raw[1] : chain[CH_BITS].quo[1];
   assign rsp_blue_out  = chain[CH_BITS].gray ? chain[CH_BITS].raw[2] : chain[CH_BITS].quo[2];
   assign rsp_alpha_out = chain[CH_BITS].alpha;

   a_below_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red_out <= chain[CH_BITS].value
                 && rsp_green_out <= chain[CH_BITS].value
                 && rsp_blue_out <= chain[CH_BITS].value)
      else $error("adjusted channel exceeds value");

endmodule

>>> tb/hsv_saturation_adjust_checker.sv
`timescale 1ns / 1ps
// Checker for hsv_saturation_adjust: watches both channels, predicts each pixel
// and compares results in order. Depends on hsa_pkg.
module hsv_saturation_adjust_checker import hsa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [CH_BITS-1:0]      req_red_in,
   input  logic [CH_BITS-1:0]      req_green_in,
   input  logic [CH_BITS-1:0]      req_blue_in,
   input  logic [CH_BITS-1:0]      req_alpha_in,
   input  logic [FACTOR_BITS-1:0]  req_sat_factor,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [CH_BITS-1:0]      rsp_red_out,
   input  logic [CH_BITS-1:0]      rsp_green_out,
   input  logic [CH_BITS-1:0]      rsp_blue_out,
   input  logic [CH_BITS-1:0]      rsp_alpha_out,
   output int                      fail_count,
   output int                      pending_pixels
);

   typedef struct packed {
      logic [CH_BITS-1:0] red;
      logic [CH_BITS-1:0] green;
      logic [CH_BITS-1:0] blue;
      logic [CH_BITS-1:0] alpha;
   } pixel_type;

   pixel_type expected_pixels[$];

   // Rescale a channel's distance below the value by the new chroma over the old, round half up.
   function automatic logic [CH_BITS-1:0] rescale_channel(
      longint unsigned c, longint unsigned v, longint unsigned d, longint unsigned k);
      longint unsigned den, num, q;
      den = d << FRAC_BITS;
      num = v * den - k * (v - c);
      q = (num + (den >> 1)) / den;
      return (q > 255) ? 8'hFF : q[CH_BITS-1:0];
   endfunction

   function automatic pixel_type adjust_saturation(
      logic [CH_BITS-1:0] r, logic [CH_BITS-1:0] g, logic [CH_BITS-1:0] b,
      logic [CH_BITS-1:0] a, logic [FACTOR_BITS-1:0] f);
      pixel_type p;
      longint unsigned v, lo, d, k;
      v = r; if (g > v) v = g; if (b > v) v = b;
      lo = r; if (g < lo) lo = g; if (b < lo) lo = b;
      d = v - lo;
      p.alpha = a;
      if (d == 0) begin
         p.red = r; p.green = g; p.blue = b;
      end else begin
         k = d * f;
         if (k > (v << FRAC_BITS)) k = v << FRAC_BITS;
         p.red   = rescale_channel(r, v, d, k);
         p.green = rescale_channel(g, v, d, k);
         p.blue  = rescale_channel(b, v, d, k);
      end
      return p;
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         expected_pixels.delete();
         fail_count     <= 0;
         pending_pixels <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_pixels = {expected_pixels, adjust_saturation(req_red_in, req_green_in,
               req_blue_in, req_alpha_in, req_sat_factor)};
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected transaction, actual %h %h %h %h", $time,
                  rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (want != {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out}) begin
                  $display("%0t: expected rgba %h %h %h %h, actual %h %h %h %h", $time,
                     want.red, want.green, want.blue, want.alpha,
                     rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_pixels <= expected_pixels.size();
      end
   end

endmodule

>>> tb/hsv_saturation_adjust_tb.sv
`timescale 1ns / 1ps
// Testbench top for hsv_saturation_adjust: drives pixels and output stalls,
// gives the verdict. Depends on hsa_pkg and hsv_saturation_adjust_checker.
module hsv_saturation_adjust_tb;
   import hsa_pkg::*;

   localparam int RANDOM_PIXELS = 530;
   localparam int IDLE_LIMIT    = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CH_BITS-1:0] req_red_in = '0, req_green_in = '0, req_blue_in = '0;
   logic [CH_BITS-1:0] req_alpha_in = '0;
   logic [FACTOR_BITS-1:0] req_sat_factor = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CH_BITS-1:0] rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out;
   int fail_count, pending_pixels;
   int idle_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   hsv_saturation_adjust i_dut (.*);

   hsv_saturation_adjust_checker i_checker (.*);

   task automatic send_pixel(input logic [7:0] r, g, b, a, input logic [15:0] f);
      int gap;
      gap = $urandom_range(19);
      if ($urandom_range(3) == 0) gap = 0;
      // drop valid only when there is a gap, so back to back stays high
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_red_in     <= r;
      req_green_in   <= g;
      req_blue_in    <= b;
      req_alpha_in   <= a;
      req_sat_factor <= f;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [15:0] random_factor();
      case ($urandom_range(5))
         0: return 16'($urandom_range(16'hFFFF));
         1: return 16'($urandom_range(64));
         2: return 16'(32'h0100 + $urandom_range(64) - 32);
         default: return 16'($urandom_range(1023));
      endcase
   endfunction

   // Random stall on the result side, with bursts of no stall.
   always @(posedge clock) begin
      int hold;
      if (reset) hold = 0;
      else if (rsp_valid && rsp_ready) hold = ($urandom_range(3) == 0) ? 0 : $urandom_range(19);
      if (hold > 0) begin
         rsp_ready <= 1'b0;
         hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("hsv_saturation_adjust: mismatch");
         $finish;
      end
   end

   initial begin
      logic [7:0] r, g, b;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // extremes, gray, zero and huge factors, equal maxima, unity factor
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      send_pixel(8'h80, 8'h80, 8'h80, 8'h5A, 16'h0200);
      send_pixel(8'hFF, 8'h00, 8'h00, 8'hA5, 16'h0100);
      send_pixel(8'hFF, 8'h00, 8'h00, 8'h01, 16'h0000);
      send_pixel(8'hC8, 8'h64, 8'h32, 8'h10, 16'hFFFF);
      send_pixel(8'hC8, 8'h64, 8'h32, 8'h10, 16'h0000);
      send_pixel(8'hC8, 8'h64, 8'h32, 8'h10, 16'h0080);
      send_pixel(8'h32, 8'hC8, 8'h64, 8'h20, 16'h0180);
      send_pixel(8'h64, 8'h32, 8'hC8, 8'h40, 16'h0100);
      send_pixel(8'hC8, 8'hC8, 8'h10, 8'h80, 16'h0140);
      send_pixel(8'hC8, 8'h10, 8'hC8, 8'h7F, 16'h00C0);
      send_pixel(8'h10, 8'hC8, 8'hC8, 8'hFE, 16'h0001);
      send_pixel(8'hC8, 8'h10, 8'h20, 8'hF0, 16'h0123);
      send_pixel(8'h01, 8'h00, 8'h00, 8'h0F, 16'h8000);
      send_pixel(8'hFF, 8'hFE, 8'hFE, 8'h55, 16'h0333);
      send_pixel(8'h55, 8'hAA, 8'h00, 8'hAA, 16'h7FFF);
      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         r = 8'($urandom_range(255)); g = 8'($urandom_range(255)); b = 8'($urandom_range(255));
         case ($urandom_range(7))
            0: begin g = r; b = r; end
            1: g = r;
            2: b = g;
            default: ;
         endcase
         send_pixel(r, g, b, 8'($urandom_range(255)), random_factor());
      end
      req_valid <= 1'b0;
      // let the checker record the last transaction before polling
      @(posedge clock);
      while (pending_pixels != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("hsv_saturation_adjust: match");
      else $display("hsv_saturation_adjust: mismatch");
      $finish;
   end

endmodule
